/* hw/rtl/bpfa_pkg.sv */
package bpfa_pkg;

  localparam int NUM_FRAMES = 65536;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  // bitmap geometry, one 32-bit word per 32 frames
  localparam int MAP_WORDS = (NUM_FRAMES + 31) / 32;
  localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WCNT_W    = $clog2(MAP_WORDS + 1);
  localparam int CNT_W     = $clog2(NUM_FRAMES + 1);
  localparam int FIDX_W    = WADDR_W + 5;

  localparam logic [31:0] FULL_WORD = 32'hFFFF_FFFF;

  // action codes
  localparam logic [1:0] ACT_INIT  = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;

  // register byte addresses
  localparam logic [2:0] REG_RESERVED_END = 3'd0;

endpackage

/* hw/rtl/bpfa_zero_find.sv */
module bpfa_zero_find
  import bpfa_pkg::*;
(
  input  logic [31:0] word,
  output logic        found,
  output logic [4:0]  bit_idx
);

  logic [31:0] inv;
  logic [31:0] lowest;

  // isolate the lowest clear bit, then encode its position
  assign inv    = ~word;
  assign lowest = inv & (~inv + 32'd1);
  assign found  = (word != FULL_WORD);

  always_comb begin
    bit_idx = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (lowest[i]) begin
        bit_idx = bit_idx | 5'(i);
      end
    end
  end

endmodule

/* hw/rtl/bitmap_page_frame_allocator_unit.sv */
// Bitmap page frame allocator: one used bit per physical page frame, kept in
// an on-chip memory of 32-bit words.
//
// channels: s_* carries one command item (action, free_addr); m_* returns
// exactly one result item (frame_addr, out_of_memory) per command. the APB
// port holds reserved_end_addr at byte address 0; it is read by init only.
//
// steps, from accept to result valid:
//   init   - one bitmap word written per cycle over all MAP_WORDS words
//   alloc  - read and check each word scanned; the scan starts at a hint word
//            below which every word is known full, so it is short in practice
//   free   - read, modify, write of one word
// throughput is one item at a time; the single-port bitmap is shared by
// init, alloc and free, and the one zero-bit finder serves the alloc check.
//
// reset: a clearing pass writes zeros to all MAP_WORDS words (2048 at the
// default size) while s_tready stays low; config writes are taken as ever.
// a stalled receiver holds the result in the output register; a new item may
// be accepted meanwhile, and its result waits until the register drains.
module bitmap_page_frame_allocator_unit
  import bpfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // apb config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [1:0] action, [33:2] free_addr, rest zero
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [31:0] frame_addr, [32] out_of_memory
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_ARD  = 3'd2;
  localparam logic [2:0] S_ACHK = 3'd3;
  localparam logic [2:0] S_FRD  = 3'd4;
  localparam logic [2:0] S_FWR  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]        state;
  logic [WCNT_W-1:0] scan_idx;
  logic [WCNT_W-1:0] hint;        // every word below this one is full
  logic [CNT_W-1:0]  init_n;      // frames to mark used during the sweep
  logic              init_reply;  // sweep came from a command, not reset
  logic [4:0]        op_bit;
  logic [31:0]       res_addr;
  logic              res_oom;
  logic [31:0]       reserved_end;
  logic              out_load;    // finished result moves to the output register

  // bitmap memory
  logic [31:0]       bitmap [MAP_WORDS];
  logic              rd_en;
  logic              wr_en;
  logic [31:0]       wr_data;
  logic [31:0]       rd_data;
  logic [WADDR_W-1:0] mem_addr;

  // command fields
  logic [1:0]        action;
  logic [31:0]       free_addr;
  logic              s_fire;

  assign action    = s_tdata[1:0];
  assign free_addr = s_tdata[33:2];
  assign s_tready  = (state == S_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign out_load  = (state == S_DONE) && (!m_tvalid || m_tready);

  // apb
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RESERVED_END[2]) ? reserved_end : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_end <= 32'd0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_RESERVED_END[2])) begin
      reserved_end <= pwdata;
    end
  end

  // reserved frame count: ceiling division, saturated at NUM_FRAMES
  logic [32:0] end_sum;
  logic [32:0] end_pages;
  logic [CNT_W-1:0] end_frames;

  assign end_sum    = {1'b0, reserved_end} + 33'(PAGE_BYTES - 1);
  assign end_pages  = end_sum >> PAGE_SHIFT;
  assign end_frames = (end_pages > 33'(NUM_FRAMES)) ? CNT_W'(NUM_FRAMES)
                                                     : CNT_W'(end_pages);

  // free request decode
  logic [31:0] free_frame;
  logic        free_ok;

  assign free_frame = free_addr >> PAGE_SHIFT;
  assign free_ok    = (free_addr != 32'd0) && (free_frame < 32'(NUM_FRAMES));

  // init sweep word value
  logic [31:0] sweep_word;
  logic [31:0] n_word;

  assign n_word = 32'(init_n >> 5);

  always_comb begin
    if (32'(scan_idx) < n_word) begin
      sweep_word = FULL_WORD;
    end else if (32'(scan_idx) == n_word) begin
      sweep_word = (32'd1 << init_n[4:0]) - 32'd1;
    end else begin
      sweep_word = 32'd0;
    end
  end

  // zero-bit finder on the word just read
  logic        zf_found;
  logic [4:0]  zf_bit;
  logic [FIDX_W-1:0] cand_frame;
  logic        cand_ok;
  logic [31:0] set_word;
  logic [FIDX_W+PAGE_SHIFT-1:0] cand_bytes;

  bpfa_zero_find u_zero_find (
    .word    (rd_data),
    .found   (zf_found),
    .bit_idx (zf_bit)
  );

  assign cand_frame = {scan_idx[WADDR_W-1:0], zf_bit};
  assign cand_ok    = zf_found && (32'(cand_frame) < 32'(NUM_FRAMES));
  assign set_word   = rd_data | (32'd1 << zf_bit);
  assign cand_bytes = {cand_frame, {PAGE_SHIFT{1'b0}}};

  // memory port control
  assign mem_addr = scan_idx[WADDR_W-1:0];

  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    wr_data = 32'd0;
    case (state)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_data = sweep_word;
      end
      S_ARD: begin
        rd_en = (32'(scan_idx) < 32'(MAP_WORDS));
      end
      S_ACHK: begin
        wr_en   = cand_ok;
        wr_data = set_word;
      end
      S_FRD: begin
        rd_en = 1'b1;
      end
      S_FWR: begin
        wr_en   = 1'b1;
        wr_data = rd_data & ~(32'd1 << op_bit);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bitmap[mem_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= bitmap[mem_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      scan_idx   <= '0;
      hint       <= '0;
      init_n     <= '0;
      init_reply <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // a new result may replace the one taken at this edge
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_fire) begin
            res_addr <= 32'd0;
            res_oom  <= 1'b0;
            case (action)
              ACT_INIT: begin
                init_n     <= end_frames;
                init_reply <= 1'b1;
                scan_idx   <= '0;
                state      <= S_INIT;
              end
              ACT_ALLOC: begin
                scan_idx <= hint;
                state    <= S_ARD;
              end
              ACT_FREE: begin
                if (free_ok) begin
                  scan_idx <= WCNT_W'(free_frame >> 5);
                  op_bit   <= free_frame[4:0];
                  state    <= S_FRD;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        // one word per cycle; words below the reserved count are full
        S_INIT: begin
          if (32'(scan_idx) == 32'(MAP_WORDS - 1)) begin
            hint  <= WCNT_W'(init_n >> 5);
            state <= init_reply ? S_DONE : S_IDLE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end

        S_ARD: begin
          if (32'(scan_idx) < 32'(MAP_WORDS)) begin
            state <= S_ACHK;
          end else begin
            res_oom <= 1'b1;
            state   <= S_DONE;
          end
        end

        S_ACHK: begin
          if (!zf_found) begin
            // full word: the hint can move past it
            scan_idx <= scan_idx + 1'b1;
            hint     <= scan_idx + 1'b1;
            state    <= S_ARD;
          end else if (cand_ok) begin
            res_addr <= 32'(cand_bytes);
            hint     <= (set_word == FULL_WORD) ? scan_idx + 1'b1 : scan_idx;
            state    <= S_DONE;
          end else begin
            // lowest clear bit lies in the unused tail of the last word
            res_oom <= 1'b1;
            state   <= S_DONE;
          end
        end

        S_FRD: begin
          state <= S_FWR;
        end

        S_FWR: begin
          if (scan_idx < hint) begin
            hint <= scan_idx;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register, loaded when the output slot is free
  logic [31:0] out_addr;
  logic        out_oom;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_addr <= res_addr;
      out_oom  <= res_oom;
    end
  end

  assign m_tdata = {7'd0, out_oom, out_addr};

endmodule
